@@ rtl/sequenced_ultrasonic_ranger_macros.svh @@
// ----------------------------------------------------------------------------
// Sequenced ultrasonic ranger assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SEQUENCED_ULTRASONIC_RANGER_MACROS_SVH
`define SEQUENCED_ULTRASONIC_RANGER_MACROS_SVH

// same-cycle implication
`define SUR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sur assertion failed");

// next-cycle implication
`define SUR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sur assertion failed");

`endif

@@ rtl/sur_pkg.sv @@
// ----------------------------------------------------------------------------
// sur_pkg
// Shared widths, register indexes and reset values of the ranger.
// ----------------------------------------------------------------------------
package sur_pkg;

	localparam int DIST_BITS = 10;
	localparam int CFG_W     = 16;
	localparam int PINS      = 4;

	typedef logic [DIST_BITS-1:0] dist_t;
	typedef logic [PINS-1:0]      pin_mask_t;
	typedef logic [1:0]           cfg_idx_t;

	// register indexes of the config port
	localparam cfg_idx_t REG_SCALE     = 2'd0;
	localparam cfg_idx_t REG_TIMEOUT   = 2'd1;
	localparam cfg_idx_t REG_THRESHOLD = 2'd2;

	localparam logic [15:0] SCALE_RST     = 16'd1114;
	localparam logic [15:0] TIMEOUT_RST   = 16'd18500;
	localparam dist_t       THRESHOLD_RST = DIST_BITS'(60);

endpackage

@@ rtl/sur_tick_if.sv @@
// ----------------------------------------------------------------------------
// sur_tick_if
// Tick channel: start request and the four echo pin levels.
// ----------------------------------------------------------------------------
interface sur_tick_if;
	import sur_pkg::*;

	logic      valid;
	logic      ready;
	logic      start_req;
	pin_mask_t echo_levels;

	modport source(output valid, start_req, echo_levels, input ready);
	modport sink(input valid, start_req, echo_levels, output ready);
endinterface

@@ rtl/sur_result_if.sv @@
// ----------------------------------------------------------------------------
// sur_result_if
// Result channel: pin drive, held distances and sweep status per tick.
// ----------------------------------------------------------------------------
interface sur_result_if;
	import sur_pkg::*;

	logic      valid;
	logic      ready;
	pin_mask_t drive_enable;
	pin_mask_t drive_level;
	dist_t     dist_left;
	dist_t     dist_center;
	dist_t     dist_right;
	dist_t     dist_back;
	pin_mask_t near_mask;
	logic      busy_res;
	logic      sweep_done;

	modport source(output valid, drive_enable, drive_level, dist_left, dist_center,
		dist_right, dist_back, near_mask, busy_res, sweep_done, input ready);
	modport sink(input valid, drive_enable, drive_level, dist_left, dist_center,
		dist_right, dist_back, near_mask, busy_res, sweep_done, output ready);
endinterface

@@ rtl/sequenced_ultrasonic_ranger.sv @@
// ----------------------------------------------------------------------------
// sequenced_ultrasonic_ranger
// Four-sensor single-pin sonar sequencer with held distances and near flags.
// ----------------------------------------------------------------------------
// Usage:
//  - tick: one item per microsecond timer tick, carrying start_req and the
//    four echo pin levels (bit0 left, bit1 center, bit2 right, bit3 back).
//  - result: one item per tick, showing pin drive, held distances, near flags,
//    busy and the sweep-done pulse as they stand after that tick.
//  - cfg: write-only register port (scale, timeout, near threshold); write it
//    only while no sweep runs and no item is in flight.
//  - Path: a tick is registered in the tick register on accept, processed
//    combinationally, and its result is loaded into the result register once that is free.
//  - Throughput: one tick per cycle while results are taken. The sensor
//    state machine and the 16x16 distance multiply are combinational,
//    between the tick register and the result register.
//  - Stall: while a result waits, the tick register still takes one more
//    item; tick.ready drops only when both registers are full and result
//    is not taken.
//  - Reset: phase idle, slot left, counters and held distances zero, config
//    at its default values, both channels empty.
// ----------------------------------------------------------------------------
module sequenced_ultrasonic_ranger #(
	parameter int TRIG_LOW_TICKS  = 2,
	parameter int TRIG_HIGH_TICKS = 5
) (
	input  logic                     clk,
	input  logic                     arst_n,
	sur_tick_if.sink                 tick,
	sur_result_if.source             result,
	input  logic                     cfg_we,
	input  sur_pkg::cfg_idx_t        cfg_index,
	input  logic [sur_pkg::CFG_W-1:0] cfg_wdata
);
	import sur_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TRIG_LOW,
		PH_TRIG_HIGH,
		PH_WAIT_RISE,
		PH_COUNT
	} phase_t;

	localparam logic [15:0] LOW_END  = 16'(TRIG_LOW_TICKS);
	localparam logic [15:0] HIGH_END = 16'(TRIG_LOW_TICKS + TRIG_HIGH_TICKS);
	localparam logic [15:0] SAT16    = 16'hFFFF;
	localparam dist_t       DIST_MAX = {DIST_BITS{1'b1}};

	// sweep order left, right, center, back
	function automatic logic [1:0] slot_pin(input logic [1:0] slot);
		logic [1:0] p;
		case (slot)
			2'd0:    p = 2'd0;
			2'd1:    p = 2'd2;
			2'd2:    p = 2'd1;
			default: p = 2'd3;
		endcase
		return p;
	endfunction

	// config registers
	logic [15:0] scale_q, timeout_q;
	dist_t       threshold_q;

	// tick register
	logic        valid_s1;
	logic        start_s1;
	pin_mask_t   levels_s1;

	// sensor state
	phase_t      phase_q;
	logic [1:0]  slot_q;
	logic [15:0] elapsed_q, echo_q;
	dist_t       held_q [PINS];

	// result register
	logic        res_valid_q;
	pin_mask_t   en_q, lv_q, near_q;
	logic        busy_q, done_q;

	// next-state values
	phase_t      phase_n;
	logic [1:0]  slot_n;
	logic [15:0] elapsed_n, echo_n;
	dist_t       held_n [PINS];
	logic        done_n;
	pin_mask_t   en_n, lv_n, near_n;

	logic        out_free, advance;
	logic [1:0]  pin;
	logic        echo;
	logic [15:0] elapsed_inc;
	logic [31:0] product;
	dist_t       dist_val;
	logic        finish;

	assign out_free   = !res_valid_q || result.ready;
	assign advance    = valid_s1 && out_free;
	assign tick.ready = !valid_s1 || out_free;

	assign pin         = slot_pin(slot_q);
	assign echo        = levels_s1[pin];
	assign elapsed_inc = (elapsed_q == SAT16) ? elapsed_q : elapsed_q + 16'd1;
	assign product     = 32'(echo_q) * 32'(scale_q);
	assign dist_val    = (product[31:16] > 16'(DIST_MAX)) ? DIST_MAX :
		product[DIST_BITS+15:16];

	always_comb begin
		phase_n   = phase_q;
		slot_n    = slot_q;
		elapsed_n = elapsed_q;
		echo_n    = echo_q;
		held_n    = held_q;
		finish    = 1'b0;
		done_n    = 1'b0;
		en_n      = '0;
		lv_n      = '0;
		near_n    = '0;

		if (phase_q == PH_IDLE) begin
			if (start_s1) begin
				phase_n   = PH_TRIG_LOW;
				slot_n    = 2'd0;
				elapsed_n = '0;
				echo_n    = '0;
			end
		end else begin
			elapsed_n = elapsed_inc;
			case (phase_q)
				PH_TRIG_LOW: begin
					if (elapsed_inc >= LOW_END)
						phase_n = PH_TRIG_HIGH;
				end
				PH_TRIG_HIGH: begin
					if (elapsed_inc >= HIGH_END)
						phase_n = PH_WAIT_RISE;
				end
				PH_WAIT_RISE: begin
					if (echo) begin
						phase_n = PH_COUNT;
						echo_n  = 16'd1;
					end
					// rise and timeout together: give up
					if (elapsed_inc >= timeout_q)
						finish = 1'b1;
				end
				PH_COUNT: begin
					if (echo) begin
						if (echo_q != SAT16)
							echo_n = echo_q + 16'd1;
						if (elapsed_inc >= timeout_q)
							finish = 1'b1;
					end else begin
						// fall wins over timeout
						held_n[pin] = dist_val;
						finish      = 1'b1;
					end
				end
				default: phase_n = PH_IDLE;
			endcase
		end

		if (finish) begin
			elapsed_n = '0;
			echo_n    = '0;
			if (slot_q == 2'd3) begin
				phase_n = PH_IDLE;
				slot_n  = 2'd0;
				done_n  = 1'b1;
			end else begin
				phase_n = PH_TRIG_LOW;
				slot_n  = slot_q + 2'd1;
			end
		end

		if (phase_n == PH_TRIG_LOW || phase_n == PH_TRIG_HIGH) begin
			en_n[slot_pin(slot_n)] = 1'b1;
			if (phase_n == PH_TRIG_HIGH)
				lv_n[slot_pin(slot_n)] = 1'b1;
		end

		// near bits: right, center, left, back
		near_n[0] = held_n[2] < threshold_q;
		near_n[1] = held_n[1] < threshold_q;
		near_n[2] = held_n[0] < threshold_q;
		near_n[3] = held_n[3] < threshold_q;
	end

	// config and tick register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= SCALE_RST;
			timeout_q   <= TIMEOUT_RST;
			threshold_q <= THRESHOLD_RST;
			valid_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SCALE:     scale_q     <= cfg_wdata;
					REG_TIMEOUT:   timeout_q   <= cfg_wdata;
					REG_THRESHOLD: threshold_q <= cfg_wdata[DIST_BITS-1:0];
					default:       ;
				endcase
			end
			if (tick.valid && tick.ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			start_s1  <= tick.start_req;
			levels_s1 <= tick.echo_levels;
		end
	end

	// sensor state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			slot_q      <= '0;
			elapsed_q   <= '0;
			echo_q      <= '0;
			held_q      <= '{default: '0};
			res_valid_q <= 1'b0;
			en_q        <= '0;
			lv_q        <= '0;
			near_q      <= '0;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (advance) begin
				phase_q     <= phase_n;
				slot_q      <= slot_n;
				elapsed_q   <= elapsed_n;
				echo_q      <= echo_n;
				held_q      <= held_n;
				res_valid_q <= 1'b1;
				en_q        <= en_n;
				lv_q        <= lv_n;
				near_q      <= near_n;
				busy_q      <= (phase_n != PH_IDLE);
				done_q      <= done_n;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// held distances are shown live; they change only when a result loads
	assign result.valid        = res_valid_q;
	assign result.drive_enable = en_q;
	assign result.drive_level  = lv_q;
	assign result.dist_left    = held_q[0];
	assign result.dist_center  = held_q[1];
	assign result.dist_right   = held_q[2];
	assign result.dist_back    = held_q[3];
	assign result.near_mask    = near_q;
	assign result.busy_res     = busy_q;
	assign result.sweep_done   = done_q;

endmodule

@@ rtl/sur_checker.sv @@
// ----------------------------------------------------------------------------
// sur_checker
// Port-level checks on the ranger, attached by bind.
// ----------------------------------------------------------------------------
`include "sequenced_ultrasonic_ranger_macros.svh"

module sur_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  tick_ready,
	input logic                  res_valid,
	input logic                  res_ready,
	input sur_pkg::pin_mask_t    drive_enable,
	input sur_pkg::pin_mask_t    drive_level,
	input sur_pkg::pin_mask_t    near_mask,
	input logic                  busy_res,
	input logic                  sweep_done
);
	import sur_pkg::*;

	// a waiting result holds
	`SUR_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(drive_enable) && $stable(drive_level) && $stable(near_mask) && $stable(busy_res) && $stable(sweep_done))

	// ticks are refused only under a result stall
	`SUR_ASSERT_NOW(a_no_idle_block, clk, arst_n, !tick_ready, res_valid && !res_ready)

	// at most one pin driven, and only a driven pin can be high
	`SUR_ASSERT_NOW(a_drive_ok, clk, arst_n, res_valid, $onehot0(drive_enable) && ((drive_level & ~drive_enable) == '0))

	// the sweep ends idle
	`SUR_ASSERT_NOW(a_done_idle, clk, arst_n, res_valid && sweep_done, !busy_res && (drive_enable == '0))

endmodule

bind sequenced_ultrasonic_ranger sur_checker u_sur_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_ready   (tick.ready),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.drive_enable (result.drive_enable),
	.drive_level  (result.drive_level),
	.near_mask    (result.near_mask),
	.busy_res     (result.busy_res),
	.sweep_done   (result.sweep_done)
);
